### rtl/core/brt_pkg.sv
// Package for the block request tracker: payload structs, codes, constants.
// Used by block_request_tracker_core; no dependencies.
`default_nettype none
package brt_pkg;

    localparam int MaxPieces  = 64;
    localparam int BlocksPer  = 16;
    localparam int BlockShift = 14;
    localparam logic [24:0] TotalMax = 25'h1FFFFFF;
    localparam logic [19:0] PieceCap = 20'd262144;

    typedef enum logic [1:0] {
        FUNC_REQ  = 2'd0,
        FUNC_RECV = 2'd1,
        FUNC_TOUT = 2'd2,
        FUNC_NONE = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_IGNORED  = 3'd0,
        ST_GRANTED  = 3'd1,
        ST_NONE     = 3'd2,
        ST_ACCEPTED = 3'd3,
        ST_VERIFIED = 3'd4,
        ST_HASHFAIL = 3'd5,
        ST_RELEASED = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        BS_FREE  = 2'd0,
        BS_ASKED = 2'd1,
        BS_GOT   = 2'd2
    } t_bstate;

    typedef enum logic [1:0] {
        REG_NUM_PIECES   = 2'd0,
        REG_PIECE_LENGTH = 2'd1,
        REG_TOTAL_SIZE   = 2'd2
    } t_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEN,
        S_SCAN,
        S_READ,
        S_PICK,
        S_UPD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]  func;
        logic [5:0]  piece;
        logic [17:0] offset;
        logic [63:0] peer_has;
        logic        hash_ok;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  piece_out;
        logic [17:0] req_offset;
        logic [14:0] req_length;
        logic        endgame;
        logic [6:0]  completed_count;
        logic        all_done;
        logic [24:0] downloaded_total;
    } t_out;

endpackage
`default_nettype wire

### rtl/core/block_request_tracker_core.sv
// Block request tracker top level: per-piece block state, request scan, endgame.
// Depends on brt_pkg.
// Order: item taken in idle, then length setup, scan, read, pick, update and strobe;
// a request runs scan, read, pick per skipped piece (plus update per examined one),
// and a scan per subtract when the endgame cursor is not below pieces. Next transfer is
// accepted in the cycle after the strobe; results cannot be stalled.
// Reset clears control, per-piece flags and counters; block-state memory and per-piece
// receive counts need no clearing (each piece is set up before they are read).
`default_nettype none
module block_request_tracker_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire brt_pkg::t_in  i_item,
    output logic               o_strobe,
    output brt_pkg::t_out      o_result,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import brt_pkg::*;

    // configuration
    logic [6:0]  r_num;
    logic [18:0] r_plen;
    logic [24:0] r_tsize;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_we  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num   <= 7'd1;
            r_plen  <= 19'd262144;
            r_tsize <= 25'd262144;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_NUM_PIECES:   r_num   <= pwdata[6:0];
                REG_PIECE_LENGTH: r_plen  <= pwdata[18:0];
                REG_TOTAL_SIZE:   r_tsize <= pwdata[24:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_NUM_PIECES:   prdata = {25'd0, r_num};
            REG_PIECE_LENGTH: prdata = {13'd0, r_plen};
            REG_TOTAL_SIZE:   prdata = {7'd0, r_tsize};
            default:          prdata = 32'd0;
        endcase
    end

    // pieces in use, clamped 1..64
    logic [6:0] pieces;
    always_comb begin
        if (r_num == 7'd0) pieces = 7'd1;
        else if (r_num > 7'd64) pieces = 7'd64;
        else pieces = r_num;
    end

    // state
    logic [31:0] mem [MaxPieces];
    logic [63:0] r_active, r_done;
    logic [4:0]  r_rcnt [MaxPieces];
    logic [6:0]  r_dcnt, r_cursor;
    logic [24:0] r_total;

    t_state r_st, n_st;
    t_in    r_in;
    logic [6:0]  r_d;          // scan step
    logic [6:0]  r_start;      // scan start, reduced below pieces
    logic [5:0]  r_idx;        // current piece
    logic        r_eg;
    logic [19:0] r_plast;      // capped length of last piece
    logic [19:0] r_pnorm;      // capped length of other pieces
    logic [31:0] r_word;
    logic [4:0]  r_cnt;        // receive count of r_idx
    t_out        r_res;

    // endgame test: done*10 >= 9*pieces
    logic eg_now;
    assign eg_now = ({4'd0, r_dcnt} * 11'd10) >= ({4'd0, pieces} * 11'd9);

    // last piece length: total - plen*(n-1), one multiply registered
    logic [31:0] prior_bytes;
    assign prior_bytes = r_plen * {25'd0, pieces - 7'd1};

    // piece length and block count of r_idx
    logic [19:0] plen_i;
    logic [4:0]  nb_i;
    assign plen_i = ({1'b0, r_idx} + 7'd1 < pieces) ? r_pnorm : r_plast;
    assign nb_i   = 5'((21'(plen_i) + 21'd16383) >> BlockShift);

    // block search in the read word
    logic [3:0] fj;
    logic       fhit;
    always_comb begin
        fj = 4'd0; fhit = 1'b0;
        for (int j = BlocksPer - 1; j >= 0; j--) begin
            if (5'(j) < nb_i &&
                (r_eg ? (r_word[2*j +: 2] != BS_GOT) : (r_word[2*j +: 2] == BS_FREE))) begin
                fj = 4'(j); fhit = 1'b1;
            end
        end
    end

    // request grants from the current piece
    logic grant;
    assign grant = !r_done[r_idx] && r_in.peer_has[r_idx] && fhit;

    logic [3:0] blk;
    assign blk = r_in.offset[17:14];
    logic [1:0] bs;
    assign bs = r_word[2*blk +: 2];
    logic       valid_blk;
    assign valid_blk = ({1'b0, r_in.piece} < pieces) && r_active[r_in.piece] &&
                       !r_done[r_in.piece] && ({1'b0, blk} < nb_i);

    logic [6:0] sidx;  // (start+d) % n
    logic [7:0] ssum;
    assign ssum = {1'b0, r_start} + {1'b0, r_d};
    assign sidx = (ssum >= {1'b0, pieces}) ? 7'(ssum - {1'b0, pieces}) : ssum[6:0];

    logic [19:0] left;
    assign left = plen_i - {fj, 14'd0};

    logic [25:0] sum;
    assign sum = {1'b0, r_total} + {6'd0, plen_i};

    assign busy     = (r_st != S_IDLE);
    assign o_strobe = (r_st == S_DONE);

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE: if (start) n_st = S_LEN;
            S_LEN:  n_st = S_SCAN;
            S_SCAN: begin
                if (r_in.func != FUNC_REQ) n_st = S_READ;
                else if (r_dcnt >= pieces || r_d >= pieces) n_st = S_DONE;
                else if (r_start >= pieces) n_st = S_SCAN;
                else n_st = S_READ;
            end
            S_READ: n_st = S_PICK;
            S_PICK: n_st = (r_in.func == FUNC_REQ &&
                            (r_done[r_idx] || r_in.peer_has[r_idx] == 1'b0)) ? S_SCAN : S_UPD;
            S_UPD:  n_st = (r_in.func == FUNC_REQ && !grant) ? S_SCAN : S_DONE;
            S_DONE: n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_active <= '0;
            r_done   <= '0;
            r_dcnt   <= '0;
            r_cursor <= '0;
            r_total  <= '0;
        end else begin
            r_st <= n_st;
            unique case (r_st)
                S_IDLE: if (start) r_in <= i_item;
                S_LEN: begin
                    r_pnorm <= (r_plen > 19'd262144) ? PieceCap : {1'b0, r_plen};
                    r_plast <= ({7'd0, r_tsize} > prior_bytes) ?
                               (((32'(r_tsize) - prior_bytes) > 32'(PieceCap)) ? PieceCap :
                                20'(32'(r_tsize) - prior_bytes)) : 20'd0;
                    r_d     <= '0;
                    r_start <= eg_now ? r_cursor : 7'd0;
                    r_eg    <= eg_now;
                    r_res   <= '0;
                    r_idx   <= r_in.piece;
                end
                S_SCAN: begin
                    if (r_in.func == FUNC_REQ) begin
                        // cursor modulo pieces by repeated subtract
                        if (r_start >= pieces) r_start <= r_start - pieces;
                        else begin
                            r_idx <= sidx[5:0];
                            r_d   <= r_d + 7'd1;
                        end
                    end
                end
                S_READ: begin
                    r_word <= mem[r_idx];
                    r_cnt  <= r_rcnt[r_idx];
                end
                S_PICK: begin
                    // lazy setup: inactive piece reads as all free
                    if (r_in.func == FUNC_REQ && !r_done[r_idx] && r_in.peer_has[r_idx] &&
                        !r_active[r_idx]) begin
                        r_word <= '0;
                        r_active[r_idx] <= 1'b1;
                        r_rcnt[r_idx] <= '0;
                        mem[r_idx] <= '0;
                    end
                end
                S_UPD: begin
                    unique case (r_in.func)
                        FUNC_REQ: begin
                            if (grant) begin
                                if (r_word[2*fj +: 2] == BS_FREE) begin
                                    mem[r_idx] <= r_word | (32'(BS_ASKED) << (2*fj));
                                end
                                if (r_eg) r_cursor <= {1'b0, r_idx} + 7'd1;
                                r_res.status     <= ST_GRANTED;
                                r_res.piece_out  <= r_idx;
                                r_res.req_offset <= {fj, 14'd0};
                                r_res.req_length <= (left < 20'd16384) ? 15'(left) : 15'd16384;
                            end
                        end
                        FUNC_RECV: if (valid_blk && bs != BS_GOT) begin
                            mem[r_idx] <= (r_word & ~(32'd3 << (2*blk))) |
                                          (32'(BS_GOT) << (2*blk));
                            r_res.piece_out <= r_idx;
                            if (r_cnt + 5'd1 == nb_i) begin
                                r_active[r_idx] <= 1'b0;
                                r_rcnt[r_idx]   <= '0;
                                if (r_in.hash_ok) begin
                                    r_done[r_idx] <= 1'b1;
                                    r_dcnt  <= r_dcnt + 7'd1;
                                    r_total <= sum[25] ? TotalMax : sum[24:0];
                                    r_res.status <= ST_VERIFIED;
                                end else r_res.status <= ST_HASHFAIL;
                            end else begin
                                r_rcnt[r_idx] <= r_cnt + 5'd1;
                                r_res.status  <= ST_ACCEPTED;
                            end
                        end
                        FUNC_TOUT: if (valid_blk && bs == BS_ASKED) begin
                            mem[r_idx] <= r_word & ~(32'd3 << (2*blk));
                            r_res.piece_out <= r_idx;
                            r_res.status    <= ST_RELEASED;
                        end
                        default: ;
                    endcase
                end
                S_DONE: ;
                default: ;
            endcase
            if (r_st == S_SCAN && r_in.func == FUNC_REQ &&
                (r_dcnt >= pieces || r_d >= pieces)) begin
                r_res.status <= ST_NONE;
            end
            if (r_st == S_UPD && r_in.func == FUNC_REQ && !grant) begin
                r_res.status <= ST_NONE;
            end
        end
    end

    // result fields that follow state after the step
    logic eg_out;
    assign eg_out = (r_in.func == FUNC_REQ) && (r_dcnt < pieces || r_res.status == ST_GRANTED)
                    && r_eg;
    always_comb begin
        o_result = r_res;
        o_result.endgame          = eg_out;
        o_result.completed_count  = r_dcnt;
        o_result.all_done         = (r_dcnt == pieces);
        o_result.downloaded_total = r_total;
    end
endmodule
`default_nettype wire
